### design/irct_pkg.sv
// ----------------------------------------------------------------------------
// irct_pkg
// Shared codes, types and command/status structs for the IRC field tagger.
// ----------------------------------------------------------------------------
package irct_pkg;

    // Field tags carried on each result.
    localparam logic [2:0] TAG_SERVER   = 3'd0;
    localparam logic [2:0] TAG_NICK     = 3'd1;
    localparam logic [2:0] TAG_USER     = 3'd2;
    localparam logic [2:0] TAG_HOST     = 3'd3;
    localparam logic [2:0] TAG_COMMAND  = 3'd4;
    localparam logic [2:0] TAG_PARAMS   = 3'd5;
    localparam logic [2:0] TAG_TRAILING = 3'd6;
    localparam logic [2:0] TAG_END      = 3'd7;

    // Line status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOPREFIX = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Delimiter characters.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Which pending piece of a byte's results is sent next.
    typedef enum logic [1:0] {
        SRC_FLUSH = 2'd0,
        SRC_SEP   = 2'd1,
        SRC_CHR   = 2'd2,
        SRC_END   = 2'd3
    } t_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic emit;
        t_src src;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pend_flush;
        logic pend_sep;
        logic pend_chr;
        logic pend_end;
        logic flush_last;
        logic out_free;
        logic acc_has_result;
    } t_sts;

endpackage

### design/irct_in_if.sv
// ----------------------------------------------------------------------------
// irct_in_if
// Input channel: one line byte per request, with its end-of-line flag.
// ----------------------------------------------------------------------------
interface irct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_line;

    modport source (output valid, output data_byte, output end_of_line, input ready);
    modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

### design/irct_out_if.sv
// ----------------------------------------------------------------------------
// irct_out_if
// Output channel: one tagged character or end marker per request.
// ----------------------------------------------------------------------------
interface irct_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_tag;
    logic [7:0] char_out;
    logic       run_last;
    logic [1:0] line_status;

    modport source (output valid, output field_tag, output char_out, output run_last,
                    output line_status, input ready);
    modport sink   (input valid, input field_tag, input char_out, input run_last,
                    input line_status, output ready);
endinterface

### design/irct_ctrl.sv
// ----------------------------------------------------------------------------
// irct_ctrl
// Controller: takes one byte at a time and sequences its pending results
// (head flush, separator, character, end marker) into the output register.
// ----------------------------------------------------------------------------
module irct_ctrl
    import irct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   any_pend;

    assign any_pend = i_sts.pend_flush | i_sts.pend_sep | i_sts.pend_chr | i_sts.pend_end;

    // Pick the next piece in fixed order and tell whether it closes the run.
    always_comb begin
        o_cmd        = '0;
        o_cmd.src    = SRC_END;
        o_in_ready   = 1'b0;
        n_state      = r_state;
        if (i_sts.pend_flush) begin
            o_cmd.src  = SRC_FLUSH;
            o_cmd.last = i_sts.flush_last & ~i_sts.pend_sep & ~i_sts.pend_chr &
                         ~i_sts.pend_end;
        end else if (i_sts.pend_sep) begin
            o_cmd.src  = SRC_SEP;
            o_cmd.last = ~i_sts.pend_chr & ~i_sts.pend_end;
        end else if (i_sts.pend_chr) begin
            o_cmd.src  = SRC_CHR;
            o_cmd.last = ~i_sts.pend_end;
        end else begin
            o_cmd.src  = SRC_END;
            o_cmd.last = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.acc_has_result) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (!any_pend) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // No result may be left pending once the controller is back to taking bytes.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !any_pend)
        else $error("pending results while idle");

    // A byte that causes results moves the controller to the busy state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.acc_has_result) |=> (r_state == S_BUSY))
        else $error("results of an accepted byte not sequenced");

    // Results are only pushed into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_sts.out_free && !o_in_ready))
        else $error("emit into an occupied output register");

endmodule

### design/irct_dpath.sv
// ----------------------------------------------------------------------------
// irct_dpath
// Datapath: parse state, head byte memory, pending result job and the
// output register.
// ----------------------------------------------------------------------------
module irct_dpath
    import irct_pkg::*;
#(
    parameter int HEAD_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_line,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [2:0] o_field_tag,
    output logic [7:0] o_char_out,
    output logic       o_run_last,
    output logic [1:0] o_line_status
);

    localparam int CW = $clog2(HEAD_MAX + 1);
    localparam int IW = $clog2(HEAD_MAX);

    typedef enum logic [9:0] {
        PH_START    = 10'b00_0000_0001,
        PH_NOPREFIX = 10'b00_0000_0010,
        PH_HEAD     = 10'b00_0000_0100,
        PH_SERVER   = 10'b00_0000_1000,
        PH_NICK     = 10'b00_0001_0000,
        PH_USER     = 10'b00_0010_0000,
        PH_HOST     = 10'b00_0100_0000,
        PH_CMD      = 10'b00_1000_0000,
        PH_PARAMS   = 10'b01_0000_0000,
        PH_TRAIL    = 10'b10_0000_0000
    } t_phase;

    // Parse state.
    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_head_cnt, n_head_cnt;
    logic            r_in_word, n_in_word;
    logic            r_need_sep, n_need_sep;
    logic            r_ovf, n_ovf;

    // Head byte memory.
    logic [7:0]      mem [HEAD_MAX];
    logic [7:0]      r_rd_data;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic            wr_en;

    // Job decoded from the accepted byte.
    logic            j_flush, j_sep, j_chr;
    logic [2:0]      j_ftag, j_ctag;
    logic [CW-1:0]   j_flen;
    logic [1:0]      j_st, j_est;

    // Registered job.
    logic            r_pend_flush, r_pend_sep, r_pend_chr, r_pend_end;
    logic [2:0]      r_ftag, r_ctag;
    logic [7:0]      r_cbyte;
    logic [CW-1:0]   r_flen;
    logic [1:0]      r_st, r_est;

    // Output register.
    logic            r_out_valid;
    logic [2:0]      r_out_tag;
    logic [7:0]      r_out_char;
    logic            r_out_last;
    logic [1:0]      r_out_st;
    logic            out_free;
    logic            flush_last;

    // Field that ends at a delimiter; leading delimiters are skipped.
    function automatic logic [1:0] word_step(input logic [7:0] c, input logic [7:0] delim,
                                             input logic in_word);
        // {advance, put}
        logic [1:0] r;
        r = '0;
        if (c == delim) begin
            r[1] = in_word;
        end else begin
            r[0] = 1'b1;
        end
        return r;
    endfunction

    // Decode the accepted byte against the current parse phase.
    always_comb begin
        logic [1:0] ws;
        logic       wf;
        logic [7:0] delim;
        t_phase     nxt;
        logic [2:0] tag;
        ws         = '0;
        wf         = 1'b0;
        delim      = CH_SPACE;
        nxt        = PH_CMD;
        tag        = TAG_SERVER;
        n_phase    = r_phase;
        n_head_cnt = r_head_cnt;
        n_in_word  = r_in_word;
        n_need_sep = r_need_sep;
        n_ovf      = r_ovf;
        wr_en      = 1'b0;
        j_flush    = 1'b0;
        j_ftag     = TAG_SERVER;
        j_flen     = r_head_cnt;
        j_sep      = 1'b0;
        j_chr      = 1'b0;
        j_ctag     = TAG_SERVER;
        case (r_phase)
            PH_START: begin
                n_phase = (i_data_byte == CH_COLON) ? PH_HEAD : PH_NOPREFIX;
            end
            PH_HEAD: begin
                if (i_data_byte == CH_BANG) begin
                    if (r_head_cnt == '0) begin
                        n_phase = PH_NICK;
                    end else begin
                        j_flush    = 1'b1;
                        j_ftag     = TAG_NICK;
                        n_head_cnt = '0;
                        n_phase    = PH_USER;
                    end
                    n_in_word = 1'b0;
                end else if (i_data_byte == CH_SPACE) begin
                    if (r_head_cnt == '0) begin
                        n_phase = PH_SERVER;
                    end else begin
                        j_flush    = 1'b1;
                        j_ftag     = TAG_SERVER;
                        n_head_cnt = '0;
                        n_phase    = PH_CMD;
                    end
                    n_in_word = 1'b0;
                end else if (r_head_cnt < CW'(HEAD_MAX)) begin
                    wr_en      = 1'b1;
                    n_head_cnt = r_head_cnt + CW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            PH_SERVER: begin
                wf = 1'b1; delim = CH_SPACE; nxt = PH_CMD;    tag = TAG_SERVER;
            end
            PH_NICK: begin
                wf = 1'b1; delim = CH_BANG;  nxt = PH_USER;   tag = TAG_NICK;
            end
            PH_USER: begin
                wf = 1'b1; delim = CH_AT;    nxt = PH_HOST;   tag = TAG_USER;
            end
            PH_HOST: begin
                wf = 1'b1; delim = CH_SPACE; nxt = PH_CMD;    tag = TAG_HOST;
            end
            PH_CMD: begin
                wf = 1'b1; delim = CH_SPACE; nxt = PH_PARAMS; tag = TAG_COMMAND;
            end
            PH_PARAMS: begin
                if (i_data_byte == CH_SPACE) begin
                    n_in_word = 1'b0;
                end else if (!r_in_word && i_data_byte == CH_COLON) begin
                    n_phase = PH_TRAIL;
                end else begin
                    j_sep      = ~r_in_word & r_need_sep;
                    j_chr      = 1'b1;
                    j_ctag     = TAG_PARAMS;
                    n_in_word  = 1'b1;
                    n_need_sep = 1'b1;
                end
            end
            PH_TRAIL: begin
                j_chr  = 1'b1;
                j_ctag = TAG_TRAILING;
            end
            default: begin
            end
        endcase

        // Shared handling of the single-word fields.
        if (wf) begin
            ws = word_step(i_data_byte, delim, r_in_word);
            if (ws[1]) begin
                n_phase    = nxt;
                n_in_word  = 1'b0;
                n_need_sep = 1'b0;
            end
            if (ws[0]) begin
                j_chr     = 1'b1;
                j_ctag    = tag;
                n_in_word = 1'b1;
            end
        end

        j_st  = n_ovf ? ST_OVERFLOW : ST_OK;
        j_est = j_st;

        // End of line: flush an open head as servername and return to line start.
        if (i_end_of_line) begin
            if (n_phase == PH_HEAD) begin
                j_flush = 1'b1;
                j_ftag  = TAG_SERVER;
                j_flen  = n_head_cnt;
            end
            j_est      = (n_phase == PH_NOPREFIX) ? ST_NOPREFIX : j_st;
            n_phase    = PH_START;
            n_head_cnt = '0;
            n_in_word  = 1'b0;
            n_need_sep = 1'b0;
            n_ovf      = 1'b0;
        end
    end

    assign out_free   = ~r_out_valid | i_out_ready;
    assign flush_last = (CW'(r_rd_idx) + CW'(1)) == r_flen;

    // Status towards the controller.
    always_comb begin
        o_sts                = '0;
        o_sts.pend_flush     = r_pend_flush;
        o_sts.pend_sep       = r_pend_sep;
        o_sts.pend_chr       = r_pend_chr;
        o_sts.pend_end       = r_pend_end;
        o_sts.flush_last     = flush_last;
        o_sts.out_free       = out_free;
        o_sts.acc_has_result = (j_flush & (j_flen != '0)) | j_sep | j_chr | i_end_of_line;
    end

    // Next flush read index: restart on a new byte, step on each flushed entry.
    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.accept) begin
            n_rd_idx = '0;
        end else if (i_cmd.emit && i_cmd.src == SRC_FLUSH) begin
            n_rd_idx = flush_last ? '0 : (r_rd_idx + IW'(1));
        end
    end

    // Head memory, written on buffered head bytes, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            mem[r_head_cnt[IW-1:0]] <= i_data_byte;
        end
        if (i_cmd.accept && wr_en && r_head_cnt[IW-1:0] == n_rd_idx) begin
            r_rd_data <= i_data_byte;
        end else begin
            r_rd_data <= mem[n_rd_idx];
        end
    end

    // Parse state and pending job flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_head_cnt   <= '0;
            r_in_word    <= 1'b0;
            r_need_sep   <= 1'b0;
            r_ovf        <= 1'b0;
            r_rd_idx     <= '0;
            r_pend_flush <= 1'b0;
            r_pend_sep   <= 1'b0;
            r_pend_chr   <= 1'b0;
            r_pend_end   <= 1'b0;
        end else begin
            r_rd_idx <= n_rd_idx;
            if (i_cmd.accept) begin
                r_phase      <= n_phase;
                r_head_cnt   <= n_head_cnt;
                r_in_word    <= n_in_word;
                r_need_sep   <= n_need_sep;
                r_ovf        <= n_ovf;
                r_pend_flush <= j_flush & (j_flen != '0);
                r_pend_sep   <= j_sep;
                r_pend_chr   <= j_chr;
                r_pend_end   <= i_end_of_line;
            end else if (i_cmd.emit) begin
                case (i_cmd.src)
                    SRC_FLUSH: if (flush_last) r_pend_flush <= 1'b0;
                    SRC_SEP:   r_pend_sep <= 1'b0;
                    SRC_CHR:   r_pend_chr <= 1'b0;
                    SRC_END:   r_pend_end <= 1'b0;
                    default:   r_pend_end <= 1'b0;
                endcase
            end
        end
    end

    // Job payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ftag  <= j_ftag;
            r_ctag  <= j_ctag;
            r_cbyte <= i_data_byte;
            r_flen  <= j_flen;
            r_st    <= j_st;
            r_est   <= j_est;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
            case (i_cmd.src)
                SRC_FLUSH: begin
                    r_out_tag  <= r_ftag;
                    r_out_char <= r_rd_data;
                    r_out_st   <= r_st;
                end
                SRC_SEP: begin
                    r_out_tag  <= TAG_PARAMS;
                    r_out_char <= CH_SPACE;
                    r_out_st   <= r_st;
                end
                SRC_CHR: begin
                    r_out_tag  <= r_ctag;
                    r_out_char <= r_cbyte;
                    r_out_st   <= r_st;
                end
                default: begin
                    r_out_tag  <= TAG_END;
                    r_out_char <= 8'd0;
                    r_out_st   <= r_est;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_tag   = r_out_tag;
    assign o_char_out    = r_out_char;
    assign o_run_last    = r_out_last;
    assign o_line_status = r_out_st;

    // The head count never runs past the buffer depth.
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_cnt <= CW'(HEAD_MAX))
        else $error("head count beyond buffer depth");

    // A flush in progress never reads past the buffered length.
    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_flush |-> (CW'(r_rd_idx) < r_flen))
        else $error("flush index beyond buffered length");

    // An end marker always closes the run of its byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tag == TAG_END) |-> r_out_last)
        else $error("end marker not flagged as last");

endmodule

### design/irc_message_field_tagger_unit.sv
// ----------------------------------------------------------------------------
// irc_message_field_tagger_unit
// Tags each content byte of an IRC line with its field, buffering the prefix
// head until its kind is known.
// ----------------------------------------------------------------------------
//  Channel | Port  | Direction | Payload
//  --------+-------+-----------+-------------------------------------------
//  input   | i_in  | sink      | data_byte[7:0], end_of_line
//  output  | o_out | source    | field_tag[2:0], char_out[7:0], run_last,
//          |       |           | line_status[1:0]
//
// A byte that causes no result leaves the controller ready for the next byte;
// one that causes results has them enter the output register one per cycle while it is free.
// A head flush reads one buffered byte per cycle from the head memory port while the output is not stalled.
// Reset is synchronous and active low; the head memory needs no clearing.
// Output stalls hold the current result and pause the sequence of results;
// the next byte is taken once the last result of the previous one is loaded.
// ----------------------------------------------------------------------------
module irc_message_field_tagger_unit
    import irct_pkg::*;
#(
    parameter int HEAD_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irct_in_if.sink     i_in,
    irct_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;

    // Controller.
    irct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    irct_dpath #(
        .HEAD_MAX (HEAD_MAX)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_in.data_byte),
        .i_end_of_line (i_in.end_of_line),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_field_tag   (o_out.field_tag),
        .o_char_out    (o_out.char_out),
        .o_run_last    (o_out.run_last),
        .o_line_status (o_out.line_status)
    );

endmodule
